FILE: hdl/nmx_pkg.sv
// Shared definitions for the 3x3 normal matrix core.
// Holds default widths, the cofactor index table and the lane status type.
// Depends on nothing.
package nmx_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // Stages beyond DATA_WIDTH: a divider lane takes DATA_WIDTH + 1 quotient-bit
   // steps, so this is that extra step plus two stages for cofactors, two for
   // the determinant, three in the lane outside its steps and one merge.
   localparam int LAT_FIXED = 9;

   // Element indices (row-major) for cofactor k = e[0]*e[1] - e[2]*e[3].
   localparam int COF_IDX [0:8][0:3] = '{
      '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
      '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
      '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
   };

   typedef struct packed {
      logic clamp;
      logic zero;
   } lane_flags_type;

endpackage

FILE: hdl/nmx_cofactor.sv
// One cofactor lane: two products in the first stage, their difference next.
// Depends on nmx_pkg for the parameter defaults.
module nmx_cofactor #(
   parameter int DATA_WIDTH = nmx_pkg::DATA_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           valid_i,
   input  logic signed [DATA_WIDTH-1:0]   a_i,
   input  logic signed [DATA_WIDTH-1:0]   b_i,
   input  logic signed [DATA_WIDTH-1:0]   c_i,
   input  logic signed [DATA_WIDTH-1:0]   d_i,
   output logic                           valid_o,
   output logic signed [2*DATA_WIDTH:0]   cof_o
);

   localparam int PW = 2 * DATA_WIDTH;

   logic signed [PW-1:0] pa_ff, pb_ff, pa_in, pb_in;
   logic signed [PW:0]   cof_ff, cof_in;
   logic                 v1_ff, v2_ff;

   assign pa_in  = a_i * b_i;
   assign pb_in  = c_i * d_i;
   assign cof_in = $signed({pa_ff[PW-1], pa_ff}) - $signed({pb_ff[PW-1], pb_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= valid_i;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff  <= pa_in;
      pb_ff  <= pb_in;
      cof_ff <= cof_in;
   end

   assign valid_o = v2_ff;
   assign cof_o   = cof_ff;

endmodule

FILE: hdl/nmx_det.sv
// Determinant from the first row and its cofactors, in two stages.
// Each cofactor is split into a low and a high half so that each product fits
// the cofactor width (2*DATA_WIDTH + 1); the cofactors are delayed alongside.
// Depends on nmx_pkg for the parameter defaults.
module nmx_det #(
   parameter int DATA_WIDTH = nmx_pkg::DATA_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           valid_i,
   input  logic signed [DATA_WIDTH-1:0]   row_i [0:2],
   input  logic signed [2*DATA_WIDTH:0]   cof_i [0:8],
   output logic                           valid_o,
   output logic signed [3*DATA_WIDTH+2:0] det_o,
   output logic signed [2*DATA_WIDTH:0]   cof_o [0:8]
);

   localparam int W    = DATA_WIDTH;
   localparam int CW   = 2 * W + 1;
   localparam int DETW = 3 * W + 3;

   logic signed [CW-1:0]   lo_ff [0:2];
   logic signed [CW-1:0]   hi_ff [0:2];
   logic signed [CW-1:0]   lo_in [0:2];
   logic signed [CW-1:0]   hi_in [0:2];
   logic signed [CW-1:0]   cof1_ff [0:8];
   logic signed [CW-1:0]   cof2_ff [0:8];
   logic signed [DETW-1:0] det_ff, det_in;
   logic                   v1_ff, v2_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lo_in[k] = row_i[k] * $signed({1'b0, cof_i[k][W-1:0]});
         hi_in[k] = row_i[k] * $signed(cof_i[k][CW-1:W]);
      end
   end

   always_comb begin
      det_in = '0;
      for (int k = 0; k < 3; k++) begin
         det_in = det_in + (DETW'(hi_ff[k]) <<< W) + DETW'(lo_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= valid_i;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      det_ff  <= det_in;
      cof1_ff <= cof_i;
      cof2_ff <= cof1_ff;
   end

   assign valid_o = v2_ff;
   assign det_o   = det_ff;
   assign cof_o   = cof2_ff;

endmodule

FILE: hdl/nmx_div_lane.sv
// One divider lane: |cofactor| * 2^(2F) / |det| by restoring division, one
// quotient bit per stage, then sign and saturation.
// Depends on nmx_pkg for defaults and the lane status type.
module nmx_div_lane #(
   parameter int DATA_WIDTH = nmx_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = nmx_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           valid_i,
   input  logic signed [2*DATA_WIDTH:0]   cof_i,
   input  logic signed [3*DATA_WIDTH+2:0] det_i,
   output logic                           valid_o,
   output logic [DATA_WIDTH-1:0]          value_o,
   output nmx_pkg::lane_flags_type        flags_o
);

   localparam int W    = DATA_WIDTH;
   localparam int CW   = 2 * W + 1;
   localparam int DETW = 3 * W + 3;
   localparam int NW   = CW + 2 * FRAC_BITS;
   localparam int RW   = (NW > DETW + W + 1) ? NW : DETW + W + 1;
   localparam int NS   = W + 1;

   // Stage A: magnitudes and sign.
   logic [CW-1:0]   cmag_in;
   logic [DETW-1:0] dmag_in;
   logic [NW-1:0]   num_a_ff;
   logic [DETW-1:0] dmag_a_ff;
   logic            neg_a_ff, zero_a_ff, v_a_ff;

   assign cmag_in = cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
   assign dmag_in = det_i[DETW-1] ? DETW'(-det_i) : DETW'(det_i);

   // Stage B: overflow test against the divisor scaled past the quotient range.
   logic            high_in;
   assign high_in = RW'(num_a_ff) >= (RW'(dmag_a_ff) << NS);

   logic [RW-1:0]   rem_ff  [0:NS];
   logic [DETW-1:0] dmag_ff [0:NS];
   logic [NS-1:0]   q_ff    [0:NS];
   logic            neg_ff  [0:NS];
   logic            high_ff [0:NS];
   logic            zero_ff [0:NS];
   logic            v_ff    [0:NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff  <= 1'b0;
         v_ff[0] <= 1'b0;
      end else begin
         v_a_ff  <= valid_i;
         v_ff[0] <= v_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      num_a_ff   <= {cmag_in, {(2 * FRAC_BITS){1'b0}}};
      dmag_a_ff  <= dmag_in;
      neg_a_ff   <= cof_i[CW-1] ^ det_i[DETW-1];
      zero_a_ff  <= (det_i == '0);
      rem_ff[0]  <= RW'(num_a_ff);
      dmag_ff[0] <= dmag_a_ff;
      q_ff[0]    <= '0;
      neg_ff[0]  <= neg_a_ff;
      high_ff[0] <= high_in;
      zero_ff[0] <= zero_a_ff;
   end

   for (genvar s = 0; s < NS; s++) begin : g_step
      logic [RW-1:0] sub_in;
      logic          ge_in;
      assign sub_in = RW'(dmag_ff[s]) << (NS - 1 - s);
      assign ge_in  = rem_ff[s] >= sub_in;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s+1] <= 1'b0;
         end else begin
            v_ff[s+1] <= v_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s+1]  <= ge_in ? rem_ff[s] - sub_in : rem_ff[s];
         q_ff[s+1]    <= {q_ff[s][NS-2:0], ge_in};
         dmag_ff[s+1] <= dmag_ff[s];
         neg_ff[s+1]  <= neg_ff[s];
         high_ff[s+1] <= high_ff[s];
         zero_ff[s+1] <= zero_ff[s];
      end
   end

   // Saturation against the signed limits of the result width.
   localparam logic [W-1:0] MAXPOS = {1'b0, {(W - 1){1'b1}}};
   localparam logic [W-1:0] MINNEG = {1'b1, {(W - 1){1'b0}}};

   logic [NS-1:0] q;
   logic [NS-1:0] qneg;
   logic          over_pos, over_neg;
   logic [W-1:0]  value_in, value_ff;
   logic          clamp_in, clamp_ff, zero_o_ff, v_o_ff;

   assign q        = q_ff[NS];
   assign qneg     = NS'(0) - q;
   assign over_pos = high_ff[NS] | q[W] | q[W-1];
   assign over_neg = high_ff[NS] | q[W] | (q[W-1] & (|q[W-2:0]));

   always_comb begin
      if (!neg_ff[NS]) begin
         value_in = over_pos ? MAXPOS : q[W-1:0];
         clamp_in = over_pos;
      end else begin
         value_in = over_neg ? MINNEG : qneg[W-1:0];
         clamp_in = over_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_o_ff <= 1'b0;
      end else begin
         v_o_ff <= v_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      clamp_ff  <= clamp_in;
      zero_o_ff <= zero_ff[NS];
   end

   assign valid_o       = v_o_ff;
   assign value_o       = value_ff;
   assign flags_o.clamp = clamp_ff;
   assign flags_o.zero  = zero_o_ff;

endmodule

FILE: hdl/nmx_merge.sv
// Merge stage: combines the nine lane results into one registered beat,
// forcing zeros on a singular matrix and gathering the clamp flags.
// Depends on nmx_pkg for defaults and the lane status type.
module nmx_merge #(
   parameter int DATA_WIDTH = nmx_pkg::DATA_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    valid_i,
   input  logic [DATA_WIDTH-1:0]   value_i [0:8],
   input  nmx_pkg::lane_flags_type flags_i [0:8],
   output logic                    valid_o,
   output logic [DATA_WIDTH-1:0]   value_o [0:8],
   output logic                    singular_o,
   output logic                    clamped_o
);

   logic [DATA_WIDTH-1:0] value_ff [0:8];
   logic [DATA_WIDTH-1:0] value_in [0:8];
   logic                  any_clamp, sing_ff, clamp_ff, valid_ff;

   always_comb begin
      any_clamp = 1'b0;
      for (int k = 0; k < 9; k++) begin
         any_clamp   = any_clamp | flags_i[k].clamp;
         value_in[k] = flags_i[0].zero ? '0 : value_i[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      sing_ff  <= flags_i[0].zero;
      clamp_ff <= any_clamp & ~flags_i[0].zero;
   end

   assign valid_o    = valid_ff;
   assign value_o    = value_ff;
   assign singular_o = sing_ff;
   assign clamped_o  = clamp_ff;

endmodule

FILE: hdl/normal_matrix_3x3_core.sv
// Top level of the 3x3 normal matrix core (inverse transpose, fixed point).
// Depends on nmx_pkg, nmx_cofactor, nmx_det, nmx_div_lane and nmx_merge.
//
// The core takes one matrix per clock and delivers its normal matrix
// as a single beat marked by rsp_valid. Busy stays low: every stage
// advances each cycle, so the receiver must take each beat when it appears.
// Each matrix passes two stages of cofactor products, two of determinant,
// the nine divider lanes, which resolve one quotient bit per pipeline stage,
// and the merge stage.
// A zero determinant gives rsp_singular with all elements zero; a quotient
// outside the signed range saturates and raises rsp_clamped.
module normal_matrix_3x3_core #(
   parameter int DATA_WIDTH = nmx_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = nmx_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_in_r1c1,
   input  logic signed [DATA_WIDTH-1:0] req_in_r1c2,
   input  logic signed [DATA_WIDTH-1:0] req_in_r1c3,
   input  logic signed [DATA_WIDTH-1:0] req_in_r2c1,
   input  logic signed [DATA_WIDTH-1:0] req_in_r2c2,
   input  logic signed [DATA_WIDTH-1:0] req_in_r2c3,
   input  logic signed [DATA_WIDTH-1:0] req_in_r3c1,
   input  logic signed [DATA_WIDTH-1:0] req_in_r3c2,
   input  logic signed [DATA_WIDTH-1:0] req_in_r3c3,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_out_r1c1,
   output logic signed [DATA_WIDTH-1:0] rsp_out_r1c2,
   output logic signed [DATA_WIDTH-1:0] rsp_out_r1c3,
   output logic signed [DATA_WIDTH-1:0] rsp_out_r2c1,
   output logic signed [DATA_WIDTH-1:0] rsp_out_r2c2,
   output logic signed [DATA_WIDTH-1:0] rsp_out_r2c3,
   output logic signed [DATA_WIDTH-1:0] rsp_out_r3c1,
   output logic signed [DATA_WIDTH-1:0] rsp_out_r3c2,
   output logic signed [DATA_WIDTH-1:0] rsp_out_r3c3,
   output logic                         rsp_singular,
   output logic                         rsp_clamped
);

   localparam int W    = DATA_WIDTH;
   localparam int CW   = 2 * W + 1;
   localparam int DETW = 3 * W + 3;

   logic signed [W-1:0]    elem [0:8];
   logic signed [W-1:0]    row_d1_ff [0:2];
   logic signed [W-1:0]    row_d2_ff [0:2];
   logic signed [CW-1:0]   cof [0:8];
   logic signed [CW-1:0]   cof_dly [0:8];
   logic signed [DETW-1:0] det;
   logic [W-1:0]           lane_value [0:8];
   logic [W-1:0]           out_value [0:8];
   nmx_pkg::lane_flags_type lane_flags [0:8];
   logic                   accept, cof_valid, det_valid;
   logic [8:0]             lane_valid;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   assign elem[0] = req_in_r1c1;
   assign elem[1] = req_in_r1c2;
   assign elem[2] = req_in_r1c3;
   assign elem[3] = req_in_r2c1;
   assign elem[4] = req_in_r2c2;
   assign elem[5] = req_in_r2c3;
   assign elem[6] = req_in_r3c1;
   assign elem[7] = req_in_r3c2;
   assign elem[8] = req_in_r3c3;

   // The first row is needed again once its cofactors are ready.
   always_ff @(posedge clock) begin
      row_d1_ff <= elem[0:2];
      row_d2_ff <= row_d1_ff;
   end

   logic [8:0] cof_valid_lane;

   for (genvar k = 0; k < 9; k++) begin : g_cof
      nmx_cofactor #(.DATA_WIDTH(W)) u_cof (
         .clock   (clock),
         .reset   (reset),
         .valid_i (accept),
         .a_i     (elem[nmx_pkg::COF_IDX[k][0]]),
         .b_i     (elem[nmx_pkg::COF_IDX[k][1]]),
         .c_i     (elem[nmx_pkg::COF_IDX[k][2]]),
         .d_i     (elem[nmx_pkg::COF_IDX[k][3]]),
         .valid_o (cof_valid_lane[k]),
         .cof_o   (cof[k])
      );
   end

   assign cof_valid = cof_valid_lane[0];

   nmx_det #(.DATA_WIDTH(W)) u_det (
      .clock   (clock),
      .reset   (reset),
      .valid_i (cof_valid),
      .row_i   (row_d2_ff),
      .cof_i   (cof),
      .valid_o (det_valid),
      .det_o   (det),
      .cof_o   (cof_dly)
   );

   for (genvar k = 0; k < 9; k++) begin : g_div
      nmx_div_lane #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
         .clock   (clock),
         .reset   (reset),
         .valid_i (det_valid),
         .cof_i   (cof_dly[k]),
         .det_i   (det),
         .valid_o (lane_valid[k]),
         .value_o (lane_value[k]),
         .flags_o (lane_flags[k])
      );
   end

   nmx_merge #(.DATA_WIDTH(W)) u_merge (
      .clock      (clock),
      .reset      (reset),
      .valid_i    (lane_valid[0]),
      .value_i    (lane_value),
      .flags_i    (lane_flags),
      .valid_o    (rsp_valid),
      .value_o    (out_value),
      .singular_o (rsp_singular),
      .clamped_o  (rsp_clamped)
   );

   assign rsp_out_r1c1 = $signed(out_value[0]);
   assign rsp_out_r1c2 = $signed(out_value[1]);
   assign rsp_out_r1c3 = $signed(out_value[2]);
   assign rsp_out_r2c1 = $signed(out_value[3]);
   assign rsp_out_r2c2 = $signed(out_value[4]);
   assign rsp_out_r2c3 = $signed(out_value[5]);
   assign rsp_out_r3c1 = $signed(out_value[6]);
   assign rsp_out_r3c2 = $signed(out_value[7]);
   assign rsp_out_r3c3 = $signed(out_value[8]);

endmodule

FILE: hdl/nmx_checker.sv
// Port-level checks for the normal matrix core, bound to the top level.
// Depends on nmx_pkg for the fixed part of the latency.
module nmx_checker #(
   parameter int DATA_WIDTH = nmx_pkg::DATA_WIDTH_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic signed [DATA_WIDTH-1:0] rsp_out_r1c1,
   input logic signed [DATA_WIDTH-1:0] rsp_out_r2c2,
   input logic signed [DATA_WIDTH-1:0] rsp_out_r3c3,
   input logic                         rsp_singular,
   input logic                         rsp_clamped
);

   localparam int LAT = DATA_WIDTH + nmx_pkg::LAT_FIXED;

   // Every result beat answers a matrix taken a fixed number of cycles before.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result beat without a matching request");

   a_no_lost: assert property (@(posedge clock) disable iff (reset)
      $past(start && !busy, LAT) && !$past(reset, LAT) && $past(!reset, 1) |-> rsp_valid)
      else $error("request beat produced no result");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |->
         rsp_out_r1c1 == '0 && rsp_out_r2c2 == '0 && rsp_out_r3c3 == '0 && !rsp_clamped)
      else $error("singular result carries data or a clamp flag");

   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         !$isunknown({rsp_out_r1c1, rsp_out_r2c2, rsp_out_r3c3, rsp_singular, rsp_clamped}))
      else $error("result beat carries unknown bits");

endmodule

bind normal_matrix_3x3_core nmx_checker #(.DATA_WIDTH(DATA_WIDTH)) u_nmx_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_out_r1c1 (rsp_out_r1c1),
   .rsp_out_r2c2 (rsp_out_r2c2),
   .rsp_out_r3c3 (rsp_out_r3c3),
   .rsp_singular (rsp_singular),
   .rsp_clamped  (rsp_clamped)
);
